// ===== src/erm_pkg.sv =====
// Shared types, constants and CORDIC arctangent table for the Euler-to-matrix unit.
package erm_pkg;

    localparam int ANGLE_BITS_DEF     = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int FIELD_W            = 16;
    localparam int CORDIC_STEPS       = 30;
    localparam int Q_FRAC             = 30;

    // CORDIC start value: gain compensation in Q30
    localparam logic signed [31:0] CORDIC_X0 = 32'sh26DD3B6A;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // one CORDIC lane word: vector, residual angle, quadrant
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [32:0] z;
        logic [1:0]         quad;
    } cord_t;

endpackage

// ===== src/erm_cordic_cell.sv =====
// One CORDIC rotation step with its pipeline register.
module erm_cordic_cell
    import erm_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  aclk,
    input  logic  en,
    input  cord_t d_in,
    output cord_t d_out
);

    cord_t cell_reg;
    cord_t cell_next;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [32:0] da;

    // rotate toward zero residual
    always_comb begin
        dx = d_in.y >>> STEP;
        dy = d_in.x >>> STEP;
        da = signed'({1'b0, ATAN_TAB[STEP]});
        cell_next.quad = d_in.quad;
        if (!d_in.z[32]) begin
            cell_next.x = d_in.x - dx;
            cell_next.y = d_in.y + dy;
            cell_next.z = d_in.z - da;
        end else begin
            cell_next.x = d_in.x + dx;
            cell_next.y = d_in.y - dy;
            cell_next.z = d_in.z + da;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign d_out = cell_reg;

endmodule

// ===== src/euler_to_rotation_matrix_unit.sv =====
// Top level: Euler angles (X, rotated Y, rotated Z) to 3x3 rotation matrix.
//
// Input channel s_*: one beat carries angle_x, angle_y, angle_z (16-bit signed,
// 2^ANGLE_BITS per turn). Output channel m_*: one beat carries the nine
// entries of Rx*Ry*Rz, signed with COEF_FRAC_BITS fraction bits, saturated
// to +-1.0.
// Pipeline: 1 phase stage, 30 CORDIC cells per axis, quadrant stage, two multiply
// stages, output register.
// Throughput: one beat per cycle while the receiver does not stall; the whole pipeline advances together.
// Every beat gives exactly one result.
// When the receiver stalls with a result held in the output register, the
// pipeline freezes and s_tready drops; bubbles are not squeezed out.
// Reset clears all valid flags; no data is lost except beats in flight.
module euler_to_rotation_matrix_unit
    import erm_pkg::*;
#(
    parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // angle_x[15:0], angle_y[31:16], angle_z[47:32]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

    localparam int PH_SH  = 32 - ANGLE_BITS;
    localparam int RSH    = Q_FRAC - COEF_FRAC_BITS;
    localparam int RSHM   = (RSH > 0) ? RSH - 1 : 0;
    localparam int NSTG   = CORDIC_STEPS + 4;   // valid flags before output reg
    localparam logic signed [35:0] RND = (RSH > 0) ? (36'sd1 <<< RSHM) : 36'sd0;
    localparam logic signed [35:0] LIM = 36'sd1 <<< COEF_FRAC_BITS;

    logic en;
    logic [NSTG-1:0] vld_reg;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;

    // Q30 product rounded back to Q30
    function automatic logic signed [32:0] qmul(input logic signed [32:0] a,
                                                input logic signed [31:0] b);
        logic signed [64:0] p;
        p = 65'(a) * 65'(b);
        p = p + (65'sd1 <<< 29);
        return p[62:30];
    endfunction

    // Q30 sum to output format, saturated
    function automatic logic [15:0] to_out(input logic signed [33:0] v);
        logic signed [35:0] t;
        t = 36'(v);
        t = (t + RND) >>> RSH;
        if (t > LIM) t = LIM;
        if (t < -LIM) t = -LIM;
        return t[15:0];
    endfunction

    // valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[NSTG-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[NSTG-1];
        end
    end

    // three CORDIC chains, one per axis
    cord_t chain [3][CORDIC_STEPS+1];
    cord_t prep_reg [3];
    cord_t prep_next [3];
    logic signed [31:0] cs_next [3][2];
    logic signed [31:0] cs_reg [3][2];   // [axis][0]=cos, [1]=sin

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [15:0] fld;
        logic [31:0] ext;
        logic [31:0] phase;

        // angle to 32-bit phase, quadrant split
        always_comb begin
            fld   = s_tdata[a*FIELD_W +: FIELD_W];
            ext   = {{16{fld[15]}}, fld};
            phase = ext << PH_SH;
            prep_next[a].x    = CORDIC_X0;
            prep_next[a].y    = '0;
            prep_next[a].z    = {3'b000, phase[29:0]};
            prep_next[a].quad = phase[31:30];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                prep_reg[a] <= prep_next[a];
            end
        end

        assign chain[a][0] = prep_reg[a];

        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
            erm_cordic_cell #(.STEP(i)) u_cell (
                .aclk  (aclk),
                .en    (en),
                .d_in  (chain[a][i]),
                .d_out (chain[a][i+1])
            );
        end

        // quadrant fold
        always_comb begin
            cord_t f;
            f = chain[a][CORDIC_STEPS];
            case (f.quad)
                2'd0: begin cs_next[a][0] = f.x;  cs_next[a][1] = f.y;  end
                2'd1: begin cs_next[a][0] = -f.y; cs_next[a][1] = f.x;  end
                2'd2: begin cs_next[a][0] = -f.x; cs_next[a][1] = -f.y; end
                default: begin cs_next[a][0] = f.y; cs_next[a][1] = -f.x; end
            endcase
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                cs_reg[a][0] <= cs_next[a][0];
                cs_reg[a][1] <= cs_next[a][1];
            end
        end
    end

    // first multiply stage
    logic signed [32:0] czsy_reg, szsy_reg, cycz_reg, cysz_reg, szcx_reg;
    logic signed [32:0] czcx_reg, cysx_reg, szsx_reg, czsx_reg, cycx_reg;
    logic signed [31:0] sy1_reg, sx1_reg, cx1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            czsy_reg <= qmul(33'(cs_reg[2][0]), cs_reg[1][1]);
            szsy_reg <= qmul(33'(cs_reg[2][1]), cs_reg[1][1]);
            cycz_reg <= qmul(33'(cs_reg[1][0]), cs_reg[2][0]);
            cysz_reg <= qmul(33'(cs_reg[1][0]), cs_reg[2][1]);
            szcx_reg <= qmul(33'(cs_reg[2][1]), cs_reg[0][0]);
            czcx_reg <= qmul(33'(cs_reg[2][0]), cs_reg[0][0]);
            cysx_reg <= qmul(33'(cs_reg[1][0]), cs_reg[0][1]);
            szsx_reg <= qmul(33'(cs_reg[2][1]), cs_reg[0][1]);
            czsx_reg <= qmul(33'(cs_reg[2][0]), cs_reg[0][1]);
            cycx_reg <= qmul(33'(cs_reg[1][0]), cs_reg[0][0]);
            sy1_reg  <= cs_reg[1][1];
            sx1_reg  <= cs_reg[0][1];
            cx1_reg  <= cs_reg[0][0];
        end
    end

    // second multiply stage: triple products, others carried
    logic signed [32:0] p10_reg, p11_reg, p20_reg, p21_reg;
    logic signed [32:0] cycz2_reg, cysz2_reg, szcx2_reg, czcx2_reg, cysx2_reg;
    logic signed [32:0] szsx2_reg, czsx2_reg, cycx2_reg;
    logic signed [31:0] sy2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p10_reg   <= qmul(czsy_reg, sx1_reg);
            p11_reg   <= qmul(szsy_reg, sx1_reg);
            p20_reg   <= qmul(czsy_reg, cx1_reg);
            p21_reg   <= qmul(szsy_reg, cx1_reg);
            cycz2_reg <= cycz_reg;
            cysz2_reg <= cysz_reg;
            szcx2_reg <= szcx_reg;
            czcx2_reg <= czcx_reg;
            cysx2_reg <= cysx_reg;
            szsx2_reg <= szsx_reg;
            czsx2_reg <= czsx_reg;
            cycx2_reg <= cycx_reg;
            sy2_reg   <= sy1_reg;
        end
    end

    // sums, rounding and saturation into the output register
    logic [143:0] m_tdata_reg;
    logic [143:0] m_tdata_next;

    always_comb begin
        m_tdata_next[15:0]    = to_out(34'(cycz2_reg));
        m_tdata_next[31:16]   = to_out(-34'(cysz2_reg));
        m_tdata_next[47:32]   = to_out(34'(sy2_reg));
        m_tdata_next[63:48]   = to_out(34'(p10_reg) + 34'(szcx2_reg));
        m_tdata_next[79:64]   = to_out(-34'(p11_reg) + 34'(czcx2_reg));
        m_tdata_next[95:80]   = to_out(-34'(cysx2_reg));
        m_tdata_next[111:96]  = to_out(-34'(p20_reg) + 34'(szsx2_reg));
        m_tdata_next[127:112] = to_out(34'(p21_reg) + 34'(czsx2_reg));
        m_tdata_next[143:128] = to_out(34'(cycx2_reg));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tdata = m_tdata_reg;

`ifndef SYNTHESIS
    // nothing leaves the block right after reset
    a_rst_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a held result blocks new input
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    // entry m00 stays within +-1.0
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && COEF_FRAC_BITS <= 14) |->
        ($signed(m_tdata[15:0]) <= 16'sd16384 && $signed(m_tdata[15:0]) >= -16'sd16384))
        else $error("m00 out of range");
`endif

endmodule

// ===== dv/euler_to_rotation_matrix_unit_tb.sv =====
// Self-checking testbench for the Euler-angle to rotation-matrix unit.
`timescale 1ns / 1ps

module euler_to_rotation_matrix_unit_tb
    import erm_pkg::*;
();

    localparam int N_ENTRIES  = 9;
    localparam int LIMIT_CYC  = 400000;
    localparam int DRAIN_CYC  = 60;

    typedef struct {
        logic [15:0] ent [N_ENTRIES];
    } matrix_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;

    matrix_t      matrix_q [$];
    int           err_cnt = 0;
    int           cyc = 0;
    bit           rx_idle_en = 1'b1;
    bit           tx_idle_en = 1'b1;
    bit           rx_hold = 1'b0;

    euler_to_rotation_matrix_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // angle_x[15:0], angle_y[31:16], angle_z[47:32]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // m00, m01, ... m22 from bit 0 up, 16 bits each
    );

    always #4 aclk = ~aclk;

    // cycle limit
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYC) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // floor shift right for 64-bit signed
    function automatic longint fshr(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return fshr(a * b + (64'sd1 <<< (Q_FRAC - 1)), Q_FRAC);
    endfunction

    // CORDIC sine and cosine in Q30 for one angle field
    task automatic trig_q30(input logic [15:0] ang, output longint c, output longint s);
        longint       x, y, z, dx, dy;
        logic [31:0]  phase;
        logic [1:0]   quad;
        x = CORDIC_X0;
        y = 0;
        phase = {ang, 16'h0};
        quad = phase[31:30];
        z = longint'(phase[29:0]);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    // Q30 to Q1.14 with rounding and saturation at +-1
    function automatic logic [15:0] to_coef(longint v);
        longint r;
        r = fshr(v + (64'sd1 <<< (Q_FRAC - COEF_FRAC_BITS_DEF - 1)),
                 Q_FRAC - COEF_FRAC_BITS_DEF);
        if (r > (64'sd1 <<< COEF_FRAC_BITS_DEF)) r = 64'sd1 <<< COEF_FRAC_BITS_DEF;
        if (r < -(64'sd1 <<< COEF_FRAC_BITS_DEF)) r = -(64'sd1 <<< COEF_FRAC_BITS_DEF);
        return r[15:0];
    endfunction

    task automatic predict_matrix(input logic [47:0] angles, output matrix_t m);
        longint cx, sx, cy, sy, cz, sz, czsy, szsy;
        trig_q30(angles[15:0], cx, sx);
        trig_q30(angles[31:16], cy, sy);
        trig_q30(angles[47:32], cz, sz);
        czsy = q30_mul(cz, sy);
        szsy = q30_mul(sz, sy);
        m.ent[0] = to_coef(q30_mul(cy, cz));
        m.ent[1] = to_coef(-q30_mul(cy, sz));
        m.ent[2] = to_coef(sy);
        m.ent[3] = to_coef(q30_mul(czsy, sx) + q30_mul(sz, cx));
        m.ent[4] = to_coef(-q30_mul(szsy, sx) + q30_mul(cz, cx));
        m.ent[5] = to_coef(-q30_mul(cy, sx));
        m.ent[6] = to_coef(-q30_mul(czsy, cx) + q30_mul(sz, sx));
        m.ent[7] = to_coef(q30_mul(szsy, cx) + q30_mul(cz, sx));
        m.ent[8] = to_coef(q30_mul(cy, cx));
    endtask

    task automatic report_mismatch(input string what);
        err_cnt++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // send one angle triple; expectation is queued on acceptance
    task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az);
        matrix_t m;
        int      gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {az, ay, ax};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_matrix({az, ay, ax}, m);
        matrix_q.push_back(m);
        @(negedge aclk);
    endtask

    task automatic stop_sending;
        s_tvalid <= 1'b0;
    endtask

    // result checker
    always @(posedge aclk) begin
        matrix_t m;
        if (aresetn && m_tvalid && m_tready) begin
            if (matrix_q.size() == 0) begin
                report_mismatch("result beat with no expectation");
            end else begin
                m = matrix_q.pop_front();
                for (int k = 0; k < N_ENTRIES; k++)
                    if (m_tdata[k*16 +: 16] !== m.ent[k])
                        report_mismatch($sformatf("entry %0d got %h exp %h",
                                        k, m_tdata[k*16 +: 16], m.ent[k]));
            end
        end
    end

    // receiver backpressure: random bursts, or a long hold when asked
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 16);
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic test_directed;
        logic [15:0] edge_vals [8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
                                      16'h4000, 16'hC000, 16'h2000, 16'h0001};
        for (int i = 0; i < 8; i++)
            send_angles(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8]);
        // quadrant boundaries and their neighbors on each axis, plus thirds of a turn
        send_angles(16'h3FFF, 16'h4001, 16'hBFFF);
        send_angles(16'h8001, 16'h7FFE, 16'h4000);
        send_angles(16'h5555, 16'hAAAA, 16'h5555);
        send_angles(16'h4000, 16'h4000, 16'h4000);
        send_angles(16'hC000, 16'hC000, 16'hC000);
        send_angles(16'h8000, 16'h8000, 16'h8000);
        stop_sending();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_angles(16'($urandom()), 16'($urandom()), 16'($urandom()));
        stop_sending();
    endtask

    // receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_backpressure;
        fork
            begin
                rx_hold = 1'b1;
                repeat (150) @(negedge aclk);
                rx_hold = 1'b0;
            end
            test_random(120);
        join
    endtask

    task automatic wait_drain;
        while (matrix_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random(700);
        test_backpressure();
        test_random(300);
        // final stretch at full rate on both sides
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random(260);
        wait_drain();
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
